[rtl/spyb_pkg.sv]
// Package with shared types, constants and register codes of the backoff idle strategy.
`timescale 1ns / 1ps

package spyb_pkg;

    // Default widths of the timestamp and of the park period.
    localparam int TIME_WIDTH_DEF   = 48;
    localparam int PERIOD_WIDTH_DEF = 32;

    // Fixed widths of the configuration word, the register index and the sleep field.
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int SLEEP_W   = 32;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] MIN_PARK_RST    = 32'd1000;
    localparam logic [CFG_W-1:0] MAX_PARK_RST    = 32'd1000000;
    localparam logic [CFG_W-1:0] MAX_SPIN_RST    = 32'd10000;
    localparam logic [CFG_W-1:0] MAX_YIELD_RST   = 32'd100000;
    localparam logic [CFG_W-1:0] DEF_TIMEOUT_RST = 32'd0;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_PARK    = 3'd0,
        REG_MAX_PARK    = 3'd1,
        REG_MAX_SPIN    = 3'd2,
        REG_MAX_YIELD   = 3'd3,
        REG_DEF_TIMEOUT = 3'd4
    } reg_idx_t;

    // Backoff phases.
    typedef enum logic [1:0] {
        PH_NOT_IDLE = 2'd0,
        PH_SPIN     = 2'd1,
        PH_YIELD    = 2'd2,
        PH_PARK     = 2'd3
    } phase_t;

    // Action codes of a result word.
    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_PAUSE = 2'd1,
        ACT_YIELD = 2'd2,
        ACT_SLEEP = 2'd3
    } action_t;

    // Status codes of a result word.
    localparam logic ST_CONTINUE  = 1'b0;
    localparam logic ST_TIMED_OUT = 1'b1;

    // Current register settings, handed from the register file to the core.
    typedef struct packed {
        logic [CFG_W-1:0] min_park_ns;
        logic [CFG_W-1:0] max_park_ns;
        logic [CFG_W-1:0] max_spin_ns;
        logic [CFG_W-1:0] max_yield_ns;
        logic [CFG_W-1:0] default_timeout_ns;
    } spyb_cfg_t;

    // One result word as produced by the core.
    typedef struct packed {
        logic               status;
        action_t            action;
        logic [SLEEP_W-1:0] sleep_ns;
    } spyb_result_t;

endpackage

[rtl/spyb_if.sv]
// Channel interfaces of the backoff idle strategy: poll, result and configuration.
`timescale 1ns / 1ps

// Poll channel: one word per idle poll.
interface spyb_poll_if #(
    parameter int TIME_WIDTH = spyb_pkg::TIME_WIDTH_DEF
);
    logic                              valid;
    logic                              ready;
    logic [TIME_WIDTH-1:0]             now_ns;
    logic                              work_done;
    logic [spyb_pkg::CFG_W-1:0]        timeout_override_ns;

    modport source (output valid, output now_ns, output work_done,
                    output timeout_override_ns, input ready);
    modport sink   (input valid, input now_ns, input work_done,
                    input timeout_override_ns, output ready);
endinterface

// Result channel: one word per poll.
interface spyb_result_if;
    logic                              valid;
    logic                              ready;
    logic                              status;
    logic [1:0]                        action;
    logic [spyb_pkg::SLEEP_W-1:0]      sleep_ns;

    modport source (output valid, output status, output action,
                    output sleep_ns, input ready);
    modport sink   (input valid, input status, input action,
                    input sleep_ns, output ready);
endinterface

// Configuration write channel.
interface spyb_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [spyb_pkg::CFG_IDX_W-1:0]    index;
    logic [spyb_pkg::CFG_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/spin_yield_park_backoff_top.sv]
// Top level of the backoff idle strategy: poll input register, core, result register.
`timescale 1ns / 1ps

// Backoff idle strategy with timeout. Each poll word carries a timestamp, a
// work-done flag and an optional timeout override, and yields exactly one
// result word (status, action, sleep length) in the same order. The block
// takes one poll per cycle while the result side keeps taking words: a poll
// is captured in an input register, then the core decides it against the
// backoff state, and the state update and the result register load together
// once the result register is free. The loop through the state registers
// sets the rate. The result register lets a new poll enter while a result
// waits to be taken.
// Configuration is written through its own channel, which is always ready;
// registers should change only while no poll is in flight.
module spin_yield_park_backoff_top #(
    parameter int TIME_WIDTH   = spyb_pkg::TIME_WIDTH_DEF,
    parameter int PERIOD_WIDTH = spyb_pkg::PERIOD_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    spyb_poll_if.sink      poll,
    spyb_result_if.source  result,
    spyb_cfg_if.sink       cfg
);
    import spyb_pkg::*;

    spyb_cfg_t             cfg_cur;
    spyb_result_t          core_res;

    logic                  s1_valid_reg;
    logic [TIME_WIDTH-1:0] s1_now_reg;
    logic                  s1_work_reg;
    logic [CFG_W-1:0]      s1_ovr_reg;

    logic                  out_valid_reg;
    spyb_result_t          out_res_reg;

    logic                  s1_move;
    logic                  poll_take;

    // Handshake: the input register empties whenever the result register can load.
    assign s1_move    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign poll.ready = !s1_valid_reg || s1_move;
    assign poll_take  = poll.valid && poll.ready;
    assign cfg.ready  = 1'b1;

    // Configuration registers.
    spyb_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_cur)
    );

    // Backoff state and decision logic.
    spyb_core #(
        .TIME_WIDTH   (TIME_WIDTH),
        .PERIOD_WIDTH (PERIOD_WIDTH)
    ) u_core (
        .clk                 (clk),
        .rst_n               (rst_n),
        .step                (s1_move),
        .now_ns              (s1_now_reg),
        .work_done           (s1_work_reg),
        .timeout_override_ns (s1_ovr_reg),
        .cfg                 (cfg_cur),
        .res                 (core_res)
    );

    // Valid flags of the two stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (poll.ready)
                s1_valid_reg <= poll.valid;
            if (s1_move)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers of the two stages.
    always_ff @(posedge clk)
    begin
        if (poll_take)
        begin
            s1_now_reg  <= poll.now_ns;
            s1_work_reg <= poll.work_done;
            s1_ovr_reg  <= poll.timeout_override_ns;
        end
        if (s1_move)
            out_res_reg <= core_res;
    end

    assign result.valid    = out_valid_reg;
    assign result.status   = out_res_reg.status;
    assign result.action   = out_res_reg.action;
    assign result.sleep_ns = out_res_reg.sleep_ns;

    // A timed-out word never carries an action.
    a_timeout_no_action: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_res_reg.status == ST_TIMED_OUT)
        |-> (out_res_reg.action == ACT_NONE))
        else $error("timed-out result carries an action");

    // Only a sleep word carries a sleep length.
    a_sleep_only_park: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_res_reg.action != ACT_SLEEP)
        |-> (out_res_reg.sleep_ns == '0))
        else $error("nonzero sleep length without sleep action");

    // A held poll stays in the input register while the result side stalls.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_move |=> s1_valid_reg && $stable(s1_now_reg))
        else $error("stalled poll lost from input register");

    // A word entering the result register while one is still waiting is a slip.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |-> (!out_valid_reg || result.ready))
        else $error("result register overwritten before it was taken");

endmodule

[rtl/spyb_cfg_regs.sv]
// Configuration register file of the backoff idle strategy.
`timescale 1ns / 1ps

module spyb_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [spyb_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [spyb_pkg::CFG_W-1:0]      wr_data,
    output spyb_pkg::spyb_cfg_t             cfg
);
    import spyb_pkg::*;

    spyb_cfg_t cfg_reg;

    // Register writes; an index beyond the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_park_ns        <= MIN_PARK_RST;
            cfg_reg.max_park_ns        <= MAX_PARK_RST;
            cfg_reg.max_spin_ns        <= MAX_SPIN_RST;
            cfg_reg.max_yield_ns       <= MAX_YIELD_RST;
            cfg_reg.default_timeout_ns <= DEF_TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_MIN_PARK:    cfg_reg.min_park_ns        <= wr_data;
                REG_MAX_PARK:    cfg_reg.max_park_ns        <= wr_data;
                REG_MAX_SPIN:    cfg_reg.max_spin_ns        <= wr_data;
                REG_MAX_YIELD:   cfg_reg.max_yield_ns       <= wr_data;
                REG_DEF_TIMEOUT: cfg_reg.default_timeout_ns <= wr_data;
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/spyb_core.sv]
// Backoff state and per-poll decision logic: timeout check, phase stepping, park doubling.
`timescale 1ns / 1ps

module spyb_core #(
    parameter int TIME_WIDTH   = spyb_pkg::TIME_WIDTH_DEF,
    parameter int PERIOD_WIDTH = spyb_pkg::PERIOD_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic [TIME_WIDTH-1:0]           now_ns,
    input  logic                            work_done,
    input  logic [spyb_pkg::CFG_W-1:0]      timeout_override_ns,
    input  spyb_pkg::spyb_cfg_t             cfg,
    output spyb_pkg::spyb_result_t          res
);
    import spyb_pkg::*;

    // Width that holds a doubled period and the park ceiling.
    localparam int CW = (PERIOD_WIDTH + 1 > CFG_W) ? PERIOD_WIDTH + 1 : CFG_W;

    phase_t                  phase_reg, phase_next;
    logic                    start_valid_reg, start_valid_next;
    logic [TIME_WIDTH-1:0]   start_time_reg, start_time_next;
    logic [TIME_WIDTH-1:0]   phase_start_reg, phase_start_next;
    logic [PERIOD_WIDTH-1:0] park_period_reg, park_period_next;

    logic [CFG_W-1:0]        tmo;
    logic                    tmo_on;
    logic [TIME_WIDTH-1:0]   start_eff;
    logic [TIME_WIDTH-1:0]   elapsed_tmo;
    logic [TIME_WIDTH-1:0]   elapsed_ph;
    logic                    timed_out;
    logic                    spin_done;
    logic                    yield_done;
    logic [PERIOD_WIDTH-1:0] min_park;
    logic [CW-1:0]           dbl;
    logic [CW-1:0]           capped;
    logic [PERIOD_WIDTH-1:0] park_dbl;

    // Effective timeout and elapsed times, both modulo the timestamp width.
    assign tmo         = (timeout_override_ns != '0) ? timeout_override_ns
                                                     : cfg.default_timeout_ns;
    assign tmo_on      = (tmo != '0);
    assign start_eff   = start_valid_reg ? start_time_reg : now_ns;
    assign elapsed_tmo = now_ns - start_eff;
    assign elapsed_ph  = now_ns - phase_start_reg;
    assign timed_out   = tmo_on && (elapsed_tmo >= TIME_WIDTH'(tmo));
    assign spin_done   = (elapsed_ph >= TIME_WIDTH'(cfg.max_spin_ns));
    assign yield_done  = (elapsed_ph >= TIME_WIDTH'(cfg.max_yield_ns));
    assign min_park    = PERIOD_WIDTH'(cfg.min_park_ns);

    // Doubled park period, capped by the ceiling register and by the period width.
    always_comb
    begin
        dbl    = CW'({park_period_reg, 1'b0});
        capped = (dbl > CW'(cfg.max_park_ns)) ? CW'(cfg.max_park_ns) : dbl;
        if (capped > CW'({PERIOD_WIDTH{1'b1}}))
            park_dbl = {PERIOD_WIDTH{1'b1}};
        else
            park_dbl = capped[PERIOD_WIDTH-1:0];
    end

    // Next state.
    always_comb
    begin
        phase_next       = phase_reg;
        start_valid_next = start_valid_reg;
        start_time_next  = start_time_reg;
        phase_start_next = phase_start_reg;
        park_period_next = park_period_reg;
        if (work_done)
        begin
            phase_next       = PH_NOT_IDLE;
            start_valid_next = 1'b0;
            park_period_next = min_park;
        end
        else
        begin
            if (tmo_on && !start_valid_reg)
            begin
                start_valid_next = 1'b1;
                start_time_next  = now_ns;
            end
            if (!timed_out)
            begin
                case (phase_reg)
                    PH_NOT_IDLE:
                    begin
                        phase_next       = PH_SPIN;
                        phase_start_next = now_ns;
                    end
                    PH_SPIN:
                    begin
                        if (spin_done)
                        begin
                            phase_next       = PH_YIELD;
                            phase_start_next = now_ns;
                        end
                    end
                    PH_YIELD:
                    begin
                        if (yield_done)
                        begin
                            phase_next       = PH_PARK;
                            phase_start_next = now_ns;
                            park_period_next = min_park;
                        end
                    end
                    default:
                    begin
                        park_period_next = park_dbl;
                    end
                endcase
            end
        end
    end

    // Result word for the poll now in the input register.
    always_comb
    begin
        res.status   = ST_CONTINUE;
        res.action   = ACT_NONE;
        res.sleep_ns = '0;
        if (!work_done)
        begin
            if (timed_out)
            begin
                res.status = ST_TIMED_OUT;
            end
            else
            begin
                case (phase_reg)
                    PH_NOT_IDLE: res.action = ACT_NONE;
                    PH_SPIN:     res.action = ACT_PAUSE;
                    PH_YIELD:    res.action = ACT_YIELD;
                    default:
                    begin
                        res.action   = ACT_SLEEP;
                        res.sleep_ns = SLEEP_W'(park_period_reg);
                    end
                endcase
            end
        end
    end

    // State registers advance once per poll.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_NOT_IDLE;
            start_valid_reg <= 1'b0;
            start_time_reg  <= '0;
            phase_start_reg <= '0;
            park_period_reg <= PERIOD_WIDTH'(MIN_PARK_RST);
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            start_valid_reg <= start_valid_next;
            start_time_reg  <= start_time_next;
            phase_start_reg <= phase_start_next;
            park_period_reg <= park_period_next;
        end
    end

endmodule

[bench/spyb_backoff_checker.sv]
// Checker of the backoff idle strategy: predicts every result word and compares it.
`timescale 1ns / 1ps

module spyb_backoff_checker (
    input  logic   clk,
    input  logic   rst_n,
    spyb_poll_if   poll,
    spyb_result_if result,
    spyb_cfg_if    cfg,
    output int     mismatch_count,
    output int     results_owed
);
    import spyb_pkg::*;

    localparam int TW = TIME_WIDTH_DEF;

    // Copies of the configuration registers.
    logic [CFG_W-1:0]   min_park;
    logic [CFG_W-1:0]   max_park;
    logic [CFG_W-1:0]   spin_span;
    logic [CFG_W-1:0]   yield_span;
    logic [CFG_W-1:0]   def_timeout;

    // Backoff state as the block should hold it.
    phase_t             cur_phase;
    logic               mark_set;
    logic [TW-1:0]      mark_ns;
    logic [TW-1:0]      phase_from_ns;
    logic [SLEEP_W-1:0] park_len;

    // Result words predicted for polls that were taken, oldest first.
    spyb_result_t       due_results[$];
    spyb_result_t       oldest;

    // Decide one poll against the backoff state and advance that state.
    function automatic spyb_result_t decide_poll(input logic [TW-1:0] now,
                                                 input logic work,
                                                 input logic [CFG_W-1:0] ovr);
        spyb_result_t     word;
        logic [CFG_W-1:0] limit;
        logic [TW-1:0]    since_mark;
        logic [TW-1:0]    in_phase;
        logic [SLEEP_W:0] twice;
        word.status   = ST_CONTINUE;
        word.action   = ACT_NONE;
        word.sleep_ns = '0;
        // Work done drops back to not idle and forgets the start mark.
        if (work)
        begin
            park_len  = min_park;
            cur_phase = PH_NOT_IDLE;
            mark_set  = 1'b0;
            return word;
        end
        // A nonzero timeout runs from the first poll with a nonzero timeout since the last work.
        limit = (ovr != '0) ? ovr : def_timeout;
        if (limit != '0)
        begin
            if (!mark_set)
            begin
                mark_ns  = now;
                mark_set = 1'b1;
            end
            since_mark = now - mark_ns;
            if (since_mark >= {{(TW-CFG_W){1'b0}}, limit})
            begin
                word.status = ST_TIMED_OUT;
                return word;
            end
        end
        // Step through the phases; elapsed times wrap with the timestamp.
        in_phase = now - phase_from_ns;
        case (cur_phase)
            PH_NOT_IDLE:
            begin
                cur_phase     = PH_SPIN;
                phase_from_ns = now;
            end
            PH_SPIN:
            begin
                word.action = ACT_PAUSE;
                if (in_phase >= {{(TW-CFG_W){1'b0}}, spin_span})
                begin
                    cur_phase     = PH_YIELD;
                    phase_from_ns = now;
                end
            end
            PH_YIELD:
            begin
                word.action = ACT_YIELD;
                if (in_phase >= {{(TW-CFG_W){1'b0}}, yield_span})
                begin
                    cur_phase     = PH_PARK;
                    park_len      = min_park;
                    phase_from_ns = now;
                end
            end
            default:
            begin
                // Park sleeps, then doubles the sleep up to the ceiling.
                word.action   = ACT_SLEEP;
                word.sleep_ns = park_len;
                twice         = {park_len, 1'b0};
                if (twice > {1'b0, max_park})
                    twice = {1'b0, max_park};
                park_len = twice[SLEEP_W-1:0];
            end
        endcase
        return word;
    endfunction

    // Follow register writes, check result words and predict for new polls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_park       = MIN_PARK_RST;
            max_park       = MAX_PARK_RST;
            spin_span      = MAX_SPIN_RST;
            yield_span     = MAX_YIELD_RST;
            def_timeout    = DEF_TIMEOUT_RST;
            cur_phase      = PH_NOT_IDLE;
            mark_set       = 1'b0;
            mark_ns        = '0;
            phase_from_ns  = '0;
            park_len       = MIN_PARK_RST;
            due_results.delete();
            mismatch_count = 0;
            results_owed   = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_MIN_PARK:    min_park    = cfg.data;
                    REG_MAX_PARK:    max_park    = cfg.data;
                    REG_MAX_SPIN:    spin_span   = cfg.data;
                    REG_MAX_YIELD:   yield_span  = cfg.data;
                    REG_DEF_TIMEOUT: def_timeout = cfg.data;
                    default: ;
                endcase
            end

            // A result word is matched against the oldest prediction.
            if (result.valid && result.ready)
            begin
                if (due_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t ns: unexpected result word, expected none, actual %0d/%0d/%0d",
                             $time, result.status, result.action, result.sleep_ns);
                end
                else
                begin
                    oldest = due_results.pop_front();
                    if (result.status !== oldest.status)
                    begin
                        mismatch_count++;
                        $display("%0t ns: status expected %0d, actual %0d",
                                 $time, oldest.status, result.status);
                    end
                    if (result.action !== oldest.action)
                    begin
                        mismatch_count++;
                        $display("%0t ns: action expected %0d, actual %0d",
                                 $time, oldest.action, result.action);
                    end
                    if (result.sleep_ns !== oldest.sleep_ns)
                    begin
                        mismatch_count++;
                        $display("%0t ns: sleep_ns expected %0d, actual %0d",
                                 $time, oldest.sleep_ns, result.sleep_ns);
                    end
                end
            end

            if (poll.valid && poll.ready)
                due_results.push_back(decide_poll(poll.now_ns, poll.work_done,
                                                  poll.timeout_override_ns));
            results_owed = due_results.size();
        end
    end

endmodule

[bench/tb.sv]
// Top of the backoff idle strategy regression: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import spyb_pkg::*;

    localparam int QUIET_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int MAX_GAP         = 18;
    localparam int RANDOM_ROUNDS   = 10;
    localparam int POLLS_PER_ROUND = 190;

    logic clk;
    logic rst_n;
    logic poll_took = 1'b0;
    logic word_took = 1'b0;
    logic cfg_took  = 1'b0;
    logic send_calm = 1'b0;
    logic take_calm = 1'b0;
    int   quiet_cycles = 0;
    int   mismatch_count;
    int   results_owed;

    spyb_poll_if   poll_ch ();
    spyb_result_if result_ch ();
    spyb_cfg_if    cfg_ch ();

    spin_yield_park_backoff_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .poll   (poll_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    spyb_backoff_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .poll           (poll_ch),
        .result         (result_ch),
        .cfg            (cfg_ch),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // 8 ns clock.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Handshakes seen at the rising edge, read by the drivers at the falling edge.
    always @(posedge clk)
    begin
        poll_took <= poll_ch.valid && poll_ch.ready;
        word_took <= result_ch.valid && result_ch.ready;
        cfg_took  <= cfg_ch.valid && cfg_ch.ready;
    end

    // Watchdog: too long without any word moving ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (poll_ch.valid && poll_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("spin_yield_park_backoff_top regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result side: random stalls before each word, with calm stretches.
    initial
    begin
        int stall;
        int taken;
        taken = 0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = take_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0)
            begin
                result_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready = 1'b1;
            do @(negedge clk); while (!word_took);
            taken++;
            if (taken % 40 == 0)
                take_calm = ($urandom_range(0, 3) == 0);
        end
    end

    // Offer one poll word after a random gap and wait until it is taken.
    task automatic send_poll(input logic [47:0] now, input logic work, input logic [31:0] ovr);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            poll_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        poll_ch.valid               = 1'b1;
        poll_ch.now_ns              = now;
        poll_ch.work_done           = work;
        poll_ch.timeout_override_ns = ovr;
        do @(negedge clk); while (!poll_took);
    endtask

    // Write one register; only called while no poll is in flight.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do @(negedge clk); while (!cfg_took);
        cfg_ch.valid = 1'b0;
    endtask

    // Stop sending and wait until every predicted word has come back.
    task automatic settle();
        poll_ch.valid = 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Phase durations and timeouts, mostly short so that every phase is reached.
    function automatic logic [31:0] draw_span();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            3, 4:    return $urandom_range(0, 20000);
            default: return $urandom_range(0, 2000);
        endcase
    endfunction

    // Park lengths, including one and the largest value of the register.
    function automatic logic [31:0] draw_park();
        case ($urandom_range(0, 7))
            0:       return 32'd1;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(1, 5000);
        endcase
    endfunction

    initial
    begin
        logic [47:0] clock_ns;
        logic [63:0] wide;
        logic [31:0] ovr;
        logic        work;
        int          step_top;
        int          work_odds;

        rst_n                       = 1'b0;
        poll_ch.valid               = 1'b0;
        poll_ch.now_ns              = '0;
        poll_ch.work_done           = 1'b0;
        poll_ch.timeout_override_ns = '0;
        cfg_ch.valid                = 1'b0;
        cfg_ch.index                = REG_MIN_PARK;
        cfg_ch.data                 = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: walk through spin and yield into park and double twice.
        send_poll(48'd0, 1'b0, 32'd0);
        send_poll(48'd5000, 1'b0, 32'd0);
        send_poll(48'd10000, 1'b0, 32'd0);
        send_poll(48'd110000, 1'b0, 32'd0);
        send_poll(48'd110000, 1'b0, 32'd0);
        send_poll(48'd110000, 1'b0, 32'd0);
        // Work done with every input bit set.
        send_poll(48'hFFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        // Start mark just below the wrap point; the next poll wraps the timestamp.
        send_poll(48'hFFFF_FFFF_FF00, 1'b0, 32'hFFFF_FFFF);
        send_poll(48'h0000_0000_2800, 1'b0, 32'hFFFF_FFFF);
        send_poll(48'd1, 1'b0, 32'd1);
        // Shortest timeout: armed on one poll, reached on the next.
        send_poll(48'd0, 1'b1, 32'd0);
        send_poll(48'd100, 1'b0, 32'd1);
        send_poll(48'd101, 1'b0, 32'd1);
        send_poll(48'd101, 1'b0, 32'd0);
        settle();

        // Zero phase durations and a park length that saturates at once.
        write_reg(REG_MIN_PARK, 32'h8000_0001);
        write_reg(REG_MAX_PARK, 32'hFFFF_FFFF);
        write_reg(REG_MAX_SPIN, 32'd0);
        write_reg(REG_MAX_YIELD, 32'd0);
        write_reg(REG_DEF_TIMEOUT, 32'hFFFF_FFFF);
        send_poll(48'd0, 1'b1, 32'd0);
        send_poll(48'd0, 1'b0, 32'd0);
        send_poll(48'd0, 1'b0, 32'd0);
        send_poll(48'd0, 1'b0, 32'd0);
        send_poll(48'd0, 1'b0, 32'd0);
        send_poll(48'd0, 1'b0, 32'd0);
        settle();

        // Zero park length sleeps zero for ever.
        write_reg(REG_MIN_PARK, 32'd0);
        write_reg(REG_MAX_PARK, 32'd1);
        write_reg(REG_DEF_TIMEOUT, 32'd0);
        send_poll(48'd0, 1'b1, 32'd0);
        send_poll(48'd7, 1'b0, 32'd0);
        send_poll(48'd7, 1'b0, 32'd0);
        send_poll(48'd7, 1'b0, 32'd0);
        send_poll(48'd7, 1'b0, 32'd0);
        send_poll(48'd7, 1'b0, 32'd0);
        settle();

        // Random rounds: new settings, then mostly well-formed idle sequences.
        clock_ns = '0;
        for (int round = 0; round < RANDOM_ROUNDS; round++)
        begin
            write_reg(REG_MIN_PARK, draw_park());
            write_reg(REG_MAX_PARK, draw_park());
            write_reg(REG_MAX_SPIN, draw_span());
            write_reg(REG_MAX_YIELD, draw_span());
            write_reg(REG_DEF_TIMEOUT, ($urandom_range(0, 1) == 0) ? 32'd0 : draw_span());
            case ($urandom_range(0, 3))
                0:       step_top = 0;
                1:       step_top = 64;
                2:       step_top = 2000;
                default: step_top = 30000;
            endcase
            work_odds = $urandom_range(6, 60);

            for (int n = 0; n < POLLS_PER_ROUND; n++)
            begin
                if (n % 32 == 0)
                    send_calm = ($urandom_range(0, 3) == 0);
                // Time mostly moves forward in small steps, now and then it jumps anywhere.
                if ($urandom_range(0, 60) == 0)
                begin
                    wide     = {$urandom, $urandom};
                    clock_ns = wide[47:0];
                end
                else
                    clock_ns = clock_ns + {16'd0, $urandom_range(0, step_top)};
                work = ($urandom_range(0, work_odds) == 0);
                case ($urandom_range(0, 11))
                    0:       ovr = $urandom;
                    1:       ovr = 32'hFFFF_FFFF;
                    2, 3:    ovr = $urandom_range(1, step_top * 8 + 1);
                    default: ovr = 32'd0;
                endcase
                send_poll(clock_ns, work, ovr);
            end
            send_calm = 1'b0;
            settle();
        end

        if (mismatch_count == 0)
            $display("spin_yield_park_backoff_top regression: pass");
        else
            $display("spin_yield_park_backoff_top regression: fail");
        $finish;
    end

endmodule
